[rtl/gradient_noise_fractal_eval_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fractal gradient noise block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_FRACTAL_EVAL_MACROS_SVH
`define GRADIENT_NOISE_FRACTAL_EVAL_MACROS_SVH

// Same-cycle implication
`define GNFE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication
`define GNFE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/gnfe_pkg.sv]
// ----------------------------------------------------------------------------
// gnfe_pkg
// Types and fixed constants of the fractal gradient noise block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gnfe_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_MOD,
		ST_OCT,
		ST_OUT
	} state_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_BASE_SCALE,
		REG_OCTAVE_COUNT,
		REG_GRID_WIDTH,
		REG_GRID_HEIGHT
	} reg_idx_t;

	// Operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// Fixed-point layout: integer cell index starts at bit 24 of the scaled point
	localparam int FRAC_BITS = 24;
	localparam int MOD_STEPS = 24;
	localparam logic [4:0] MOD_LAST = 5'(MOD_STEPS - 1);

	// Fade polynomial coefficients
	localparam logic [37:0] FADE_C10 = 38'd10;
	localparam logic [37:0] FADE_C6 = 38'd6;
	localparam logic [37:0] FADE_C15 = 38'd15;
	localparam logic [19:0] FADE_ONE = 20'd65536;

	// Per-octave sequence steps
	localparam logic [2:0] STEP_CORNER_LAST = 3'd3;
	localparam logic [2:0] STEP_DOT_LAST = 3'd4;
	localparam logic [2:0] STEP_LERP_X = 3'd5;
	localparam logic [2:0] STEP_LERP_Y = 3'd6;
	localparam logic [2:0] STEP_ACCUM = 3'd7;

	// Datapath widths
	localparam int LW = 38;
	localparam int SUMW = 42;

endpackage

`default_nettype wire

[rtl/gradient_noise_fractal_eval.sv]
// ----------------------------------------------------------------------------
// gradient_noise_fractal_eval
// Fractal 2-D gradient noise over a wrapping grid of stored gradients.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Beat
// in        sink       in_valid / in_ready    operation, point, entry, gradient
// out       source     out_valid / out_ready  noise_value
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load beat writes one gradient memory entry when it is accepted. An evaluate beat
// runs through the accept, a multiply state, a bit-serial cell wrap over the
// 24 integer bits, then per octave four corner reads through the one gradient
// memory read port with fade, blend and accumulate, and an output state.
// Reset idles the sequencer, sets configuration defaults and clears output valid;
// the gradient memory holds no reset. A stalled output holds the last cycle of the item.
`timescale 1ns / 1ps
`default_nettype none

`include "gradient_noise_fractal_eval_macros.svh"

module gradient_noise_fractal_eval
	import gnfe_pkg::*;
#(
	parameter int MAX_GRID_SIDE = 64,
	parameter int MAX_OCTAVES = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               operation,
	input  wire logic [31:0]        point_x,
	input  wire logic [31:0]        point_y,
	input  wire logic [11:0]        entry_index,
	input  wire logic signed [15:0] gradient_x,
	input  wire logic signed [15:0] gradient_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      noise_value,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	localparam int DEPTH = MAX_GRID_SIDE * MAX_GRID_SIDE;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_GRID_SIDE);
	localparam int SW = $clog2(MAX_GRID_SIDE + 1);
	localparam int EW = (SW > 7) ? SW : 7;
	localparam int OW = $clog2(MAX_OCTAVES + 1);
	localparam int CTW = (OW > 4) ? OW : 4;

	// Wrap step: (2c + b) mod g, with c already below g
	function automatic logic [CW-1:0] mod_step(input logic [CW-1:0] c, input logic b,
		input logic [SW-1:0] g);
		logic [CW:0] t;
		t = {c, b};
		if (t >= (CW+1)'(g))
			mod_step = CW'(t - (CW+1)'(g));
		else
			mod_step = CW'(t);
	endfunction

	// Blend a toward b by fade f (Q1.16), floored
	function automatic logic signed [LW-1:0] lerp(input logic signed [LW-1:0] a,
		input logic signed [LW-1:0] b, input logic [16:0] f);
		logic signed [LW:0]    diff;
		logic signed [LW+18:0] prod;
		diff = (LW+1)'(b) - (LW+1)'(a);
		prod = diff * $signed({1'b0, f});
		lerp = a + LW'(prod >>> 16);
	endfunction

	// Fade polynomial middle term from w*w and w
	function automatic logic [19:0] fade_q(input logic [31:0] sq, input logic [15:0] w);
		logic [37:0] t;
		t = (FADE_C10 << 32) + FADE_C6 * 38'(sq) - ((FADE_C15 * 38'(w)) << 16);
		fade_q = t[35:16];
	endfunction

	// Fade final product, clamped to one
	function automatic logic [16:0] fade_f(input logic [15:0] w3, input logic [19:0] q);
		logic [35:0] p;
		p = 36'(w3) * 36'(q);
		if (p[35:16] > FADE_ONE)
			fade_f = 17'(FADE_ONE);
		else
			fade_f = p[32:16];
	endfunction

	state_t state_q, state_d;

	logic [15:0] base_scale_q;
	logic [3:0]  octave_count_q;
	logic [6:0]  grid_width_q;
	logic [6:0]  grid_height_q;

	logic [SW-1:0] gw_eff, gh_eff;
	logic [OW-1:0] cnt_eff;

	logic [4:0]    bit_q;
	logic [2:0]    step_q;
	logic [OW-1:0] oct_q;
	logic          out_valid_q;
	logic signed [15:0] noise_q;

	logic [23:0]   hx_q, hy_q;
	logic [23:0]   fx_q, fy_q;
	logic [CW-1:0] cx_q, cy_q;
	logic [31:0]   sqx_q, sqy_q;
	logic [15:0]   w3x_q, w3y_q;
	logic [19:0]   qx_q, qy_q;
	logic [16:0]   ux_q, uy_q;
	logic signed [LW-1:0] d_q [4];
	logic signed [LW-1:0] r0_q, r1_q, n_q;
	logic signed [SUMW-1:0] sum_q;

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic [AW-1:0] rd_addr;
	logic          rd_en;

	logic [15:0]   wx, wy;
	logic [CW-1:0] x1, y1, col, row;
	logic [1:0]    corner;
	logic signed [34:0] dot;
	logic signed [SUMW-1:0] term, res;
	logic signed [15:0] noise_d;
	logic          in_fire, eval_fire, out_free;

	// Clamp configuration to usable ranges
	always_comb begin
		if (grid_width_q == 7'd0)
			gw_eff = SW'(1);
		else if (EW'(grid_width_q) > EW'(MAX_GRID_SIDE))
			gw_eff = SW'(MAX_GRID_SIDE);
		else
			gw_eff = SW'(grid_width_q);
		if (grid_height_q == 7'd0)
			gh_eff = SW'(1);
		else if (EW'(grid_height_q) > EW'(MAX_GRID_SIDE))
			gh_eff = SW'(MAX_GRID_SIDE);
		else
			gh_eff = SW'(grid_height_q);
		if (CTW'(octave_count_q) > CTW'(MAX_OCTAVES))
			cnt_eff = OW'(MAX_OCTAVES);
		else
			cnt_eff = OW'(octave_count_q);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign noise_value = noise_q;
	assign in_fire = in_valid && in_ready;
	assign eval_fire = in_fire && (operation == OP_EVAL);
	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (eval_fire)
					state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_MOD;
			ST_MOD: begin
				if (bit_q == MOD_LAST)
					state_d = (cnt_eff == '0) ? ST_OUT : ST_OCT;
			end
			ST_OCT: begin
				if (step_q == STEP_ACCUM && (OW+1)'(oct_q) + 1'b1 == (OW+1)'(cnt_eff))
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Corner address, dot product, octave term and output saturation
	always_comb begin
		wx = fx_q[23:8];
		wy = fy_q[23:8];
		x1 = ((CW+1)'(cx_q) + 1'b1 == (CW+1)'(gw_eff)) ? '0 : CW'((CW+1)'(cx_q) + 1'b1);
		y1 = ((CW+1)'(cy_q) + 1'b1 == (CW+1)'(gh_eff)) ? '0 : CW'((CW+1)'(cy_q) + 1'b1);
		col = step_q[0] ? x1 : cx_q;
		row = step_q[1] ? y1 : cy_q;
		rd_addr = AW'((CW+SW)'(row) * (CW+SW)'(gw_eff) + (CW+SW)'(col));
		rd_en = (state_q == ST_OCT) && (step_q <= STEP_CORNER_LAST);
		corner = 2'(step_q - 3'd1);
		dot = 35'($signed(rdata_q[15:0]) * $signed({corner[0], wx}))
			+ 35'($signed(rdata_q[31:16]) * $signed({corner[1], wy}));
		term = SUMW'(n_q) >>> ((OW+1)'(oct_q) + 1'b1);
		res = sum_q >>> 15;
		if (res > SUMW'(32767))
			noise_d = 16'sh7fff;
		else if (res < -SUMW'(32768))
			noise_d = -16'sh8000;
		else
			noise_d = 16'(res);
	end

	// Gradient memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_fire && operation == OP_LOAD && 32'(entry_index) < 32'(DEPTH))
			mem[AW'(entry_index)] <= {gradient_y, gradient_x};
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_scale_q <= 16'd256;
			octave_count_q <= 4'd1;
			grid_width_q <= 7'd64;
			grid_height_q <= 7'd64;
			bit_q <= '0;
			step_q <= '0;
			oct_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_BASE_SCALE: base_scale_q <= cfg_data;
					REG_OCTAVE_COUNT: octave_count_q <= cfg_data[3:0];
					REG_GRID_WIDTH: grid_width_q <= cfg_data[6:0];
					REG_GRID_HEIGHT: grid_height_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (state_q == ST_MUL) begin
				bit_q <= '0;
				step_q <= '0;
				oct_q <= '0;
			end
			if (state_q == ST_MOD)
				bit_q <= bit_q + 5'd1;
			if (state_q == ST_OCT) begin
				step_q <= step_q + 3'd1;
				if (step_q == STEP_ACCUM)
					oct_q <= oct_q + 1'b1;
			end
			// Drop a taken result, load a finished one
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL: begin
				// Scale the full point: upper bits sit in fx_q, low byte in hx_q
				hx_q <= 24'((48'({fx_q, hx_q[7:0]}) * 48'(base_scale_q)) >> FRAC_BITS);
				hy_q <= 24'((48'({fy_q, hy_q[7:0]}) * 48'(base_scale_q)) >> FRAC_BITS);
				fx_q <= 24'(48'({fx_q, hx_q[7:0]}) * 48'(base_scale_q));
				fy_q <= 24'(48'({fy_q, hy_q[7:0]}) * 48'(base_scale_q));
				cx_q <= '0;
				cy_q <= '0;
				sum_q <= '0;
			end
			ST_MOD: begin
				// Reduce the integer cell index one bit per cycle
				cx_q <= mod_step(cx_q, hx_q[23], gw_eff);
				cy_q <= mod_step(cy_q, hy_q[23], gh_eff);
				hx_q <= hx_q << 1;
				hy_q <= hy_q << 1;
			end
			ST_OCT: begin
				case (step_q)
					3'd0: begin
						sqx_q <= 32'(wx) * 32'(wx);
						sqy_q <= 32'(wy) * 32'(wy);
					end
					3'd1: begin
						w3x_q <= 16'((32'(sqx_q[31:16]) * 32'(wx)) >> 16);
						w3y_q <= 16'((32'(sqy_q[31:16]) * 32'(wy)) >> 16);
						qx_q <= fade_q(sqx_q, wx);
						qy_q <= fade_q(sqy_q, wy);
					end
					3'd2: begin
						ux_q <= fade_f(w3x_q, qx_q);
						uy_q <= fade_f(w3y_q, qy_q);
					end
					default: ;
				endcase
				if (step_q != 3'd0 && step_q <= STEP_DOT_LAST)
					d_q[corner] <= LW'(dot);
				if (step_q == STEP_LERP_X) begin
					r0_q <= lerp(d_q[0], d_q[1], ux_q);
					r1_q <= lerp(d_q[2], d_q[3], ux_q);
				end
				if (step_q == STEP_LERP_Y)
					n_q <= lerp(r0_q, r1_q, uy_q);
				// Accumulate and advance to the next octave
				if (step_q == STEP_ACCUM) begin
					sum_q <= sum_q + term;
					cx_q <= mod_step(cx_q, fx_q[23], gw_eff);
					cy_q <= mod_step(cy_q, fy_q[23], gh_eff);
					fx_q <= fx_q << 1;
					fy_q <= fy_q << 1;
				end
			end
			ST_OUT: begin
				if (out_free)
					noise_q <= noise_d;
			end
			default: begin
				if (eval_fire) begin
					hx_q <= point_x[23:0];
					hy_q <= point_y[23:0];
					fx_q <= point_x[31:8];
					fy_q <= point_y[31:8];
				end
			end
		endcase
	end

	`GNFE_ASSERT_IMP(a_cell_x_wrapped, state_q == ST_OCT, (CW+1)'(cx_q) < (CW+1)'(gw_eff))
	`GNFE_ASSERT_IMP(a_octave_in_range, state_q == ST_OCT, oct_q < cnt_eff)
	`GNFE_ASSERT_NXT(a_eval_starts, eval_fire, state_q == ST_MUL)

endmodule

`default_nettype wire
